[rtl/core/idrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input delta rate limiter package
// Shared types and register indexes for the rate limiter block.
// ----------------------------------------------------------------------------
package idrl_pkg;

   localparam int CODE_REGS    = 4;
   localparam int STALE_SHIFT  = 2;   // stale age is four times the delay
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_TYPE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_SLOT0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF    = 3'd7;

   localparam logic signed [15:0] SAT16_LO = 16'sh8000;
   localparam logic signed [15:0] SAT16_HI = 16'sh7fff;

   typedef struct packed {
      logic       enable;
      logic [7:0] match_type;
      logic [2:0] code_count;
   } cfg_type;

   // One classified event as it travels from the front to the back.
   typedef struct packed {
      logic               hit;      // event belongs to a limited slot
      logic               sync;
      logic signed [31:0] value;
      logic [31:0]        now_ms;
   } item_type;

endpackage

[rtl/core/idrl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate limiter front end
// Classifies an incoming event: bypass, or the first code slot it matches.
// ----------------------------------------------------------------------------
module idrl_front #(
   parameter int SLOTS  = 4,
   parameter int SLOT_W = 2
) (
   input  idrl_pkg::cfg_type          cfg,
   input  logic [SLOTS-1:0][15:0]     codes,
   input  logic [7:0]                 event_type,
   input  logic [15:0]                event_code,
   input  logic signed [31:0]         event_value,
   input  logic                       event_sync,
   input  logic [31:0]                now_ms,
   output idrl_pkg::item_type         item,
   output logic [SLOT_W-1:0]          slot
);
   import idrl_pkg::*;

   logic found;

   // Scan from the top down so the lowest matching slot is the one kept.
   always_comb begin
      found = 1'b0;
      slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (5'(i) < {2'b00, cfg.code_count} && codes[i] == event_code) begin
            found = 1'b1;
            slot  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      item.hit    = cfg.enable && (event_type == cfg.match_type) && found;
      item.sync   = event_sync;
      item.value  = event_value;
      item.now_ms = now_ms;
   end

endmodule

[rtl/core/idrl_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate limiter decoupling queue
// Two-entry register queue between the front end and the slot engine.
// ----------------------------------------------------------------------------
module idrl_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [1:0][WIDTH-1:0] entry_ff;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/idrl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate limiter slot engine
// Holds the per-slot remainder, sync and report time and forms each result.
// ----------------------------------------------------------------------------
module idrl_back #(
   parameter int SLOTS  = 4,
   parameter int SLOT_W = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  idrl_pkg::item_type  item,
   input  logic [SLOT_W-1:0]   slot,
   input  logic [15:0]         holdoff,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_value,
   output logic                rsp_sync,
   output logic                rsp_forward
);
   import idrl_pkg::*;

   logic signed [15:0] rem_ff [SLOTS];
   logic               held_ff [SLOTS];
   logic [31:0]        last_ff [SLOTS];

   logic               valid_ff, valid_in;
   logic signed [31:0] value_ff, value_in;
   logic               sync_ff, sync_in;
   logic               fwd_ff, fwd_in;

   logic [31:0]        age;
   logic               stale, soon;
   logic signed [15:0] rem_eff;
   logic               held_eff;
   logic signed [32:0] sum;
   logic signed [15:0] sat;

   assign q_pop       = q_valid && (!valid_ff || rsp_ready);
   assign rsp_valid   = valid_ff;
   assign rsp_value   = value_ff;
   assign rsp_sync    = sync_ff;
   assign rsp_forward = fwd_ff;

   always_comb begin
      age      = item.now_ms - last_ff[slot];
      stale    = age >= (32'(holdoff) << STALE_SHIFT);
      soon     = age < {16'd0, holdoff};
      rem_eff  = stale ? 16'sd0 : rem_ff[slot];
      held_eff = stale ? 1'b0 : held_ff[slot];
      sum      = 33'(item.value) + 33'(rem_eff);
      // Saturate to int16: the sum fits when all bits above bit 15 agree.
      if (sum < 33'(SAT16_LO)) begin
         sat = SAT16_LO;
      end else if (sum > 33'(SAT16_HI)) begin
         sat = SAT16_HI;
      end else begin
         sat = sum[15:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      sync_in  = sync_ff;
      fwd_in   = fwd_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (q_pop) begin
         valid_in = 1'b1;
         if (!item.hit) begin
            value_in = item.value;
            sync_in  = item.sync;
            fwd_in   = 1'b1;
         end else if (soon) begin
            value_in = 32'sd0;
            sync_in  = 1'b0;
            fwd_in   = 1'b0;
         end else begin
            value_in = 32'(sat);
            sync_in  = item.sync | held_eff;
            fwd_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      sync_ff  <= sync_in;
      fwd_ff   <= fwd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            rem_ff[i]  <= 16'sd0;
            held_ff[i] <= 1'b0;
            last_ff[i] <= 32'd0;
         end
      end else if (q_pop && item.hit) begin
         if (soon) begin
            rem_ff[slot]  <= sat;
            held_ff[slot] <= held_eff | item.sync;
         end else begin
            rem_ff[slot]  <= 16'sd0;
            held_ff[slot] <= 1'b0;
            last_ff[slot] <= item.now_ms;
         end
      end
   end

endmodule

[rtl/core/input_delta_rate_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input delta rate limiter
// Holds back events of one type and a few codes until a minimum time has
// passed, summing the held deltas into the next report that goes through.
// ----------------------------------------------------------------------------
// The block takes one event per clock while its queue has room, and returns
// exactly one result per event, in order. The front end classifies each
// event and writes it into a two-entry queue; the slot engine reads one
// entry per cycle while its result register is free or being taken, updates
// that slot's remainder, sync and report time in the same cycle and registers
// the result, so events of the same code may follow each other directly. With
// no back pressure the rate is one event per cycle. Configuration must only
// be written while no event is in flight.
// ----------------------------------------------------------------------------
module input_delta_rate_limiter #(
   parameter int SLOTS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // csr_index selects the register, csr_wdata carries its value.
   input  logic                              csr_we,
   input  logic [idrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [idrl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [79:0]                       req_tdata,  // event_code, event_value, now_ms
   input  logic [7:0]                        req_tuser,  // event_type
   input  logic                              req_tlast,  // event_sync
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // out_value
   output logic                              rsp_tuser,  // forward
   output logic                              rsp_tlast   // out_sync
);
   import idrl_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ITEM_W = $bits(item_type);
   localparam int Q_W    = ITEM_W + SLOT_W;

   cfg_type                cfg_ff;
   logic [SLOTS-1:0][15:0] codes_ff;
   logic [15:0]            delay_ff;

   item_type               f_item, b_item;
   logic [SLOT_W-1:0]      f_slot, b_slot;
   logic                   q_full, q_valid, q_pop;
   logic [Q_W-1:0]         q_out;
   logic signed [31:0]     out_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         codes_ff <= '0;
         delay_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLE:     cfg_ff.enable     <= csr_wdata[0];
            REG_MATCH_TYPE: cfg_ff.match_type <= csr_wdata[7:0];
            REG_CODE_COUNT: cfg_ff.code_count <= csr_wdata[2:0];
            REG_HOLDOFF:    delay_ff          <= csr_wdata;
            default: begin
               // Code slot registers; slots beyond the block's size drop the write.
               for (int k = 0; k < SLOTS; k++) begin
                  if (k < CODE_REGS && csr_index == REG_CODE_SLOT0 + CSR_IDX_W'(k)) begin
                     codes_ff[k] <= csr_wdata;
                  end
               end
            end
         endcase
      end
   end

   idrl_front #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_front (
      .cfg         (cfg_ff),
      .codes       (codes_ff),
      .event_type  (req_tuser),
      .event_code  (req_tdata[15:0]),
      .event_value (req_tdata[47:16]),
      .event_sync  (req_tlast),
      .now_ms      (req_tdata[79:48]),
      .item        (f_item),
      .slot        (f_slot)
   );

   assign req_tready = !q_full;

   idrl_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data ({f_item, f_slot}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_out)
   );

   assign b_item = q_out[Q_W-1:SLOT_W];
   assign b_slot = q_out[SLOT_W-1:0];

   idrl_back #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .item        (b_item),
      .slot        (b_slot),
      .holdoff     (delay_ff),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_value   (out_value),
      .rsp_sync    (rsp_tlast),
      .rsp_forward (rsp_tuser)
   );

   assign rsp_tdata = out_value;

endmodule

[verif/tb_input_delta_rate_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input delta rate limiter testbench
// Drives events through the limiter under several register settings, keeps
// its own copy of the per-code slot state to work out every result, and
// compares each result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_input_delta_rate_limiter;
   import idrl_pkg::*;

   localparam int SLOT_COUNT  = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 500;

   typedef struct packed {
      logic [7:0]         kind;
      logic [15:0]        code;
      logic signed [31:0] delta;
      logic               sync;
      logic [31:0]        stamp;
   } stim_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               sync;
      logic               fwd;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [79:0]           req_tdata = '0;   // event_code, event_value, now_ms
   logic [7:0]            req_tuser = '0;   // event_type
   logic                  req_tlast = 1'b0; // event_sync
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // out_value
   logic                  rsp_tuser;        // forward
   logic                  rsp_tlast;        // out_sync

   // Register mirror and slot state of the limiter.
   logic               cfg_enable = 1'b0;
   logic [7:0]         cfg_match = '0;
   logic [2:0]         cfg_count = '0;
   logic [15:0]        cfg_code [SLOT_COUNT] = '{default: '0};
   logic [15:0]        cfg_delay = '0;
   logic signed [15:0] slot_rem [SLOT_COUNT] = '{default: '0};
   logic               slot_sync [SLOT_COUNT] = '{default: 1'b0};
   logic [31:0]        slot_last [SLOT_COUNT] = '{default: '0};

   stim_type    events_to_send [$];
   outcome_type expected_results [$];
   outcome_type due;
   int          mismatches = 0;
   int          cycles = 0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   int          holds_requested = 0;
   int          holds_served = 0;
   int          hold_left = 0;

   input_delta_rate_limiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v < longint'(SAT16_LO)) return SAT16_LO;
      if (v > longint'(SAT16_HI)) return SAT16_HI;
      return v[15:0];
   endfunction

   function automatic outcome_type limit_event(input stim_type ev);
      outcome_type        r;
      int                 slot;
      int                 n;
      logic [31:0]        age;
      logic signed [15:0] merged;
      r.value = ev.delta;
      r.sync  = ev.sync;
      r.fwd   = 1'b1;
      slot    = -1;
      n       = (cfg_count > SLOT_COUNT) ? SLOT_COUNT : int'(cfg_count);
      if (!cfg_enable || ev.kind != cfg_match) return r;
      for (int i = 0; i < n; i++) begin
         if (slot < 0 && cfg_code[i] == ev.code) slot = i;
      end
      if (slot < 0) return r;
      age = ev.stamp - slot_last[slot];
      if (age >= (32'(cfg_delay) << 2)) begin
         slot_rem[slot]  = '0;
         slot_sync[slot] = 1'b0;
      end
      if (age < 32'(cfg_delay)) begin
         slot_rem[slot]  = clamp16(longint'(slot_rem[slot]) + longint'($signed(ev.delta)));
         slot_sync[slot] = slot_sync[slot] | ev.sync;
         return '0;
      end
      merged          = clamp16(longint'($signed(ev.delta)) + longint'(slot_rem[slot]));
      r.value         = {{16{merged[15]}}, merged};
      r.sync          = ev.sync | slot_sync[slot];
      slot_rem[slot]  = '0;
      slot_sync[slot] = 1'b0;
      slot_last[slot] = ev.stamp;
      return r;
   endfunction

   // Driver: the head of the queue is on the bus until its transfer completes.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(limit_event(events_to_send[0]));
            void'(events_to_send.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else if (events_to_send.size() != 0
                      && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {events_to_send[0].stamp, events_to_send[0].delta,
                           events_to_send[0].code};
            req_tuser  <= events_to_send[0].kind;
            req_tlast  <= events_to_send[0].sync;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, started by a request from the stimulus.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (holds_served != holds_requested) begin
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_requested;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %0d sync %0b forward %0b",
                        $signed(rsp_tdata), rsp_tlast, rsp_tuser);
         end else begin
            due = expected_results.pop_front();
            if (rsp_tdata !== due.value || rsp_tlast !== due.sync || rsp_tuser !== due.fwd) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected value %0d sync %0b forward %0b, ",
                            "got value %0d sync %0b forward %0b"},
                           due.value, due.sync, due.fwd,
                           $signed(rsp_tdata), rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (events_to_send.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_ENABLE:     cfg_enable = val[0];
         REG_MATCH_TYPE: cfg_match  = val[7:0];
         REG_CODE_COUNT: cfg_count  = val[2:0];
         REG_HOLDOFF:    cfg_delay  = val;
         default:        cfg_code[2'(idx - REG_CODE_SLOT0)] = val;
      endcase
   endtask

   task automatic program_limiter(input logic en, input logic [7:0] kind,
                                  input logic [2:0] count, input logic [15:0] codes [SLOT_COUNT],
                                  input logic [15:0] delay);
      write_reg(REG_ENABLE, 16'(en));
      write_reg(REG_MATCH_TYPE, 16'(kind));
      write_reg(REG_CODE_COUNT, 16'(count));
      for (int i = 0; i < SLOT_COUNT; i++)
         write_reg(REG_CODE_SLOT0 + CSR_IDX_W'(i), codes[i]);
      write_reg(REG_HOLDOFF, delay);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_event(input logic [7:0] kind, input logic [15:0] code,
                              input logic [31:0] delta, input logic sync,
                              input logic [31:0] stamp);
      stim_type ev;
      ev = '{kind, code, delta, sync, stamp};
      events_to_send.push_back(ev);
   endtask

   initial begin
      stim_type    ev;
      logic [15:0] codes [SLOT_COUNT];
      logic [15:0] delay;
      logic [2:0]  count;
      int unsigned stamp;
      int unsigned step;
      int          d;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Duplicate code in slots one and three: slot one must win.
      codes = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0001};
      program_limiter(1'b1, 8'h03, 3'd4, codes, 16'd10);
      queue_event(8'h04, 16'h0000, 32'h7FFF_FFFF, 1'b1, 32'd50);
      queue_event(8'h03, 16'h1234, 32'h8000_0000, 1'b0, 32'd60);
      queue_event(8'h03, 16'h0000, 32'h7FFF_FFFF, 1'b0, 32'd100);
      queue_event(8'h03, 16'h0000, 32'h8000_0000, 1'b1, 32'd101);
      queue_event(8'h03, 16'h0000, -32'sd5, 1'b0, 32'd105);
      queue_event(8'h03, 16'h0000, 32'd100, 1'b0, 32'd111);
      queue_event(8'h03, 16'h0001, 32'd7, 1'b1, 32'd0);
      queue_event(8'h03, 16'h0001, 32'd8, 1'b0, 32'd5);
      queue_event(8'h03, 16'h0001, 32'd9, 1'b0, 32'd45);
      queue_event(8'h03, 16'hFFFF, -32'sd3, 1'b0, 32'hFFFF_FFF0);
      queue_event(8'h03, 16'hFFFF, 32'd4, 1'b1, 32'd3);
      queue_event(8'h03, 16'hFFFF, 32'd6, 1'b0, 32'd5);
      queue_event(8'h03, 16'hFFFF, 32'd1, 1'b0, 32'd13);
      wait_drained();

      // Longest delay and a code count beyond the slot number.
      codes = '{16'h0010, 16'h0020, 16'h0030, 16'h0040};
      program_limiter(1'b1, 8'hFF, 3'd7, codes, 16'hFFFF);
      queue_event(8'hFF, 16'h0040, 32'd20, 1'b1, 32'd5);
      queue_event(8'hFF, 16'h0040, 32'd30, 1'b0, 32'h0004_0000);
      queue_event(8'hFF, 16'h0010, 32'd1, 1'b0, 32'h0004_0001);
      wait_drained();

      program_limiter(1'b0, 8'h00, 3'd4, codes, 16'd100);
      queue_event(8'h00, 16'h0010, 32'h8000_0000, 1'b1, 32'd7);
      queue_event(8'h00, 16'h0020, 32'h7FFF_FFFF, 1'b0, 32'd8);
      wait_drained();

      program_limiter(1'b1, 8'h00, 3'd0, codes, 16'd0);
      queue_event(8'h00, 16'h0010, 32'd77, 1'b1, 32'd9);
      wait_drained();

      // Zero delay: matching events always go through.
      program_limiter(1'b1, 8'h00, 3'd2, codes, 16'd0);
      queue_event(8'h00, 16'h0010, -32'sd40000, 1'b0, 32'd9);
      queue_event(8'h00, 16'h0020, 32'd12, 1'b1, 32'd9);
      queue_event(8'h00, 16'h0030, 32'd13, 1'b0, 32'd9);
      wait_drained();

      for (int p = 0; p < 15; p++) begin
         if (p < 5) begin
            sender_idle_pct   = 7;
            receiver_idle_pct = 70;
         end else if (p < 10) begin
            sender_idle_pct   = 70;
            receiver_idle_pct = 7;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         count = ($urandom_range(0, 9) < 6) ? 3'd4 : 3'($urandom_range(0, 7));
         for (int i = 0; i < SLOT_COUNT; i++)
            codes[i] = (i > 0 && $urandom_range(0, 3) == 0)
                       ? codes[$urandom_range(0, i - 1)] : 16'($urandom_range(0, 65535));
         case ($urandom_range(0, 5))
            0:       delay = 16'd0;
            1:       delay = 16'd1;
            2, 3:    delay = 16'($urandom_range(2, 30));
            4:       delay = 16'hFFFF;
            default: delay = 16'($urandom_range(0, 65535));
         endcase
         program_limiter($urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)), count,
                         codes, delay);
         stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                             : $urandom;
         if (p == 10) holds_requested++;
         for (int k = 0; k < 105; k++) begin
            ev.kind = ($urandom_range(0, 9) < 8) ? cfg_match : 8'($urandom_range(0, 255));
            ev.code = ($urandom_range(0, 9) < 8) ? codes[$urandom_range(0, SLOT_COUNT - 1)]
                                                 : 16'($urandom_range(0, 65535));
            if (delay == 0) begin
               step = $urandom_range(0, 3);
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: step = $urandom_range(0, 32'(delay) + 32'(delay) / 2);
                  6, 7:             step = $urandom_range(0, delay / 3);
                  8:                step = $urandom_range(4 * delay, 5 * delay + 1);
                  default:          step = $urandom;
               endcase
            end
            stamp += step;
            ev.stamp = stamp;
            case ($urandom_range(0, 7))
               0, 1, 2: d = int'($urandom_range(0, 200)) - 100;
               3:       d = int'($urandom_range(0, 80000)) - 40000;
               4:       d = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               default: d = $urandom;
            endcase
            ev.delta = d;
            ev.sync  = 1'($urandom_range(0, 1));
            events_to_send.push_back(ev);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
